@@ src/tmsf_pkg.sv @@
// Shared constants, types and cell control bundle of the trimmed mean sample filter.
package tmsf_pkg;

	localparam int SAMPLE_W     = 12;
	localparam int WINDOW_DEF   = 30;
	localparam int DROP_LOW_DEF = 10;
	localparam int KEEP_DEF     = 10;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic write;
		logic occupied;
		logic at_fill;
	} cell_ctl_t;

endpackage

@@ src/tmsf_if.sv @@
// Valid/ready channel interfaces for sample words and average words.
interface tmsf_sample_if;
	logic             valid;
	logic             ready;
	tmsf_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface tmsf_average_if;
	logic             valid;
	logic             ready;
	tmsf_pkg::sample_t average;

	modport source (output valid, output average, input ready);
	modport sink (input valid, input average, output ready);
endinterface

@@ src/tmsf_cell.sv @@
// One cell of the sorted insertion chain.
module tmsf_cell (
	input  logic                clk,
	input  tmsf_pkg::cell_ctl_t ctl,
	input  tmsf_pkg::sample_t   sample,
	input  tmsf_pkg::sample_t   prev_val,
	input  logic                prev_gt,
	output tmsf_pkg::sample_t   val,
	output tmsf_pkg::sample_t   next_val,
	output logic                gt
);
	import tmsf_pkg::*;

	sample_t val_q;

	assign val = val_q;
	assign gt  = ctl.occupied && (val_q > sample);

	always_comb begin
		if (prev_gt) begin
			next_val = prev_val;
		end else if (gt || ctl.at_fill) begin
			next_val = sample;
		end else begin
			next_val = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.write && (ctl.occupied || ctl.at_fill)) begin
			val_q <= next_val;
		end
	end

endmodule

@@ src/tmsf_accum.sv @@
// Serial sum of the kept ranks, division by the kept count and output register.
module tmsf_accum #(
	parameter int KEEP = tmsf_pkg::KEEP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  tmsf_pkg::sample_t kept [KEEP],
	output logic              busy,
	tmsf_average_if.source    results
);
	import tmsf_pkg::*;

	localparam int SUM_W   = $clog2(((1 << SAMPLE_W) - 1) * KEEP + 1);
	localparam int SHIFT   = SUM_W + $clog2(KEEP);
	localparam int RECIP_W = SUM_W + 1;
	localparam longint RECIP_L = ((longint'(1) << SHIFT) + KEEP - 1) / KEEP;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int CNT_W   = $clog2(KEEP + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic              valid_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  acc_q;
	logic [PROD_W-1:0] prod_q;
	sample_t           snap_q [KEEP];

	assign busy            = (state_q != ST_IDLE);
	assign results.valid   = valid_q;
	assign results.average = prod_q[SHIFT +: SAMPLE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						snap_q  <= kept;
						acc_q   <= '0;
						cnt_q   <= CNT_W'(KEEP);
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					acc_q <= acc_q + SUM_W'(snap_q[0]);
					for (int k = 0; k < KEEP - 1; k++) begin
						snap_q[k] <= snap_q[k+1];
					end
					snap_q[KEEP-1] <= '0;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= PROD_W'(acc_q) * PROD_W'(RECIP);
					valid_q <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (results.ready) begin
						valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					valid_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ src/trimmed_mean_sample_filter.sv @@
// Top level of the trimmed mean sample filter.
// Sample words enter a chain of WINDOW cells that keeps the current window in
// ascending order, and one word is taken every clock cycle. On the last word
// of a window the kept ranks are copied out and summed one per cycle, then
// divided by KEEP into the average word, which is held until it is taken.
// The next window fills meanwhile; only its last word waits while the
// previous sum is still running or its average has not been taken yet.
module trimmed_mean_sample_filter #(
	parameter int WINDOW   = tmsf_pkg::WINDOW_DEF,
	parameter int DROP_LOW = tmsf_pkg::DROP_LOW_DEF,
	parameter int KEEP     = tmsf_pkg::KEEP_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	tmsf_sample_if.sink    samples,
	tmsf_average_if.source results
);
	import tmsf_pkg::*;

	localparam int CNT_W = $clog2(WINDOW);

	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             last;
	logic             acc_busy;

	sample_t   val      [WINDOW];
	sample_t   next_val [WINDOW];
	logic      gt       [WINDOW];
	cell_ctl_t ctl      [WINDOW];
	sample_t   kept     [KEEP];

	assign last          = (count_q == CNT_W'(WINDOW - 1));
	assign samples.ready = !(last && acc_busy);
	assign accept        = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= last ? '0 : count_q + CNT_W'(1);
		end
	end

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		assign ctl[i].write    = accept;
		assign ctl[i].occupied = (32'(count_q) > i);
		assign ctl[i].at_fill  = (32'(count_q) == i);

		if (i == 0) begin : g_head
			tmsf_cell u_cell (
				.clk      (clk),
				.ctl      (ctl[i]),
				.sample   (samples.sample),
				.prev_val ('0),
				.prev_gt  (1'b0),
				.val      (val[i]),
				.next_val (next_val[i]),
				.gt       (gt[i])
			);
		end else begin : g_body
			tmsf_cell u_cell (
				.clk      (clk),
				.ctl      (ctl[i]),
				.sample   (samples.sample),
				.prev_val (val[i-1]),
				.prev_gt  (gt[i-1]),
				.val      (val[i]),
				.next_val (next_val[i]),
				.gt       (gt[i])
			);
		end
	end

	for (genvar k = 0; k < KEEP; k++) begin : g_kept
		if (DROP_LOW + k < WINDOW) begin : g_rank
			assign kept[k] = next_val[DROP_LOW + k];
		end else begin : g_zero
			assign kept[k] = '0;
		end
	end

	tmsf_accum #(
		.KEEP (KEEP)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept && last),
		.kept    (kept),
		.busy    (acc_busy),
		.results (results)
	);

	a_load_starts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> acc_busy)
		else $error("Completed window did not start the sum.");

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> (last && acc_busy))
		else $error("Input stalled outside the last word of a window.");

	for (genvar i = 1; i < WINDOW; i++) begin : g_order_chk
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			(32'(count_q) > i) |-> (val[i-1] <= val[i]))
			else $error("Window store lost ascending order.");
	end

endmodule

@@ sim/tb_trimmed_mean_sample_filter.sv @@
// Self-checking testbench that streams sample words and checks each window's trimmed mean.
`timescale 1ns / 100ps

module tb_trimmed_mean_sample_filter;
	import tmsf_pkg::*;

	localparam int WINDOW        = WINDOW_DEF;
	localparam int DROP_LOW      = DROP_LOW_DEF;
	localparam int KEEP          = KEEP_DEF;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = KEEP + 10;

	typedef enum int {
		SHAPE_UNIFORM,
		SHAPE_RISING,
		SHAPE_FALLING,
		SHAPE_FLAT,
		SHAPE_RAILS,
		SHAPE_BAND
	} window_shape_e;

	logic clk;
	logic arst_n;

	tmsf_sample_if  sample_bus ();
	tmsf_average_if average_bus ();

	trimmed_mean_sample_filter #(
		.WINDOW  (WINDOW),
		.DROP_LOW(DROP_LOW),
		.KEEP    (KEEP)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(sample_bus),
		.results(average_bus)
	);

	sample_t window_sorted[$];
	sample_t expected_averages[$];
	bit      idle_enable;
	bit      hold_req;
	int      failures;
	int      words_sent;
	int      windows_sent;
	int      averages_checked;
	int      quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic sample_t trimmed_average();
		int unsigned sum;
		int unsigned divisor;
		sum = 0;
		divisor = (KEEP > 0) ? KEEP : 1;
		for (int k = 0; k < KEEP; k++) begin
			if (DROP_LOW + k < WINDOW)
				sum += window_sorted[DROP_LOW + k];
		end
		return sample_t'(sum / divisor);
	endfunction

	task automatic predict_sample(input sample_t s);
		int pos;
		pos = window_sorted.size();
		while (pos > 0 && window_sorted[pos - 1] > s)
			pos--;
		window_sorted.insert(pos, s);
		if (window_sorted.size() == WINDOW) begin
			expected_averages.push_back(trimmed_average());
			window_sorted.delete();
			windows_sent++;
		end
	endtask

	task automatic send_sample(input sample_t s);
		if (idle_enable) begin
			while ($urandom_range(99) < 30) begin
				sample_bus.valid <= 1'b0;
				@(posedge clk);
			end
		end
		sample_bus.valid  <= 1'b1;
		sample_bus.sample <= s;
		@(posedge clk);
		while (!sample_bus.ready)
			@(posedge clk);
		predict_sample(s);
		words_sent++;
	endtask

	function automatic sample_t make_sample(input window_shape_e shape, input int idx,
			input int level);
		int v;
		case (shape)
			SHAPE_RISING:  v = idx * 136 + $urandom_range(15);
			SHAPE_FALLING: v = 4095 - idx * 136 - $urandom_range(15);
			SHAPE_FLAT:    v = level;
			SHAPE_RAILS:   v = $urandom_range(1) ? 4095 : 0;
			SHAPE_BAND:    v = level + $urandom_range(16) - 8;
			default:       v = $urandom_range(4095);
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return sample_t'(v);
	endfunction

	task automatic send_window(input window_shape_e shape);
		int level;
		level = (shape == SHAPE_FLAT && $urandom_range(3) == 0) ?
			($urandom_range(1) ? 4095 : 0) : $urandom_range(4095);
		for (int i = 0; i < WINDOW; i++)
			send_sample(make_sample(shape, i, level));
	endtask

	task automatic test_extremes();
		// Alternating rails make the kept ranks half zero and half full scale,
		// so the mean lands on a fraction and checks truncation.
		for (int i = 0; i < WINDOW; i++)
			send_sample((i % 2 == 0) ? sample_t'(4095) : sample_t'(0));
	endtask

	task automatic test_random_windows(input int count);
		window_shape_e shape;
		for (int w = 0; w < count; w++) begin
			shape = window_shape_e'($urandom_range(SHAPE_BAND));
			if ($urandom_range(1))
				shape = SHAPE_UNIFORM;
			send_window(shape);
		end
	endtask

	task automatic test_streaming(input int count);
		idle_enable = 1'b0;
		for (int w = 0; w < count; w++)
			send_window(SHAPE_UNIFORM);
		idle_enable = 1'b1;
	endtask

	task automatic test_backpressure();
		// The receiver holds off while whole windows keep arriving, so the last
		// word of the following window has to wait for the held average.
		idle_enable = 1'b0;
		hold_req = 1'b1;
		for (int w = 0; w < 3; w++)
			send_window(SHAPE_UNIFORM);
		idle_enable = 1'b1;
	endtask

	initial begin : receiver
		average_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				average_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			average_bus.ready <= idle_enable ? ($urandom_range(99) >= 30) : 1'b1;
		end
	end

	always @(posedge clk) begin : check_averages
		sample_t want;
		if (arst_n && average_bus.valid && average_bus.ready) begin
			if (expected_averages.size() == 0) begin
				$display("%0t: average %0d arrived with no expected value", $time,
					average_bus.average);
				failures++;
			end else begin
				want = expected_averages.pop_front();
				averages_checked++;
				if (average_bus.average !== want) begin
					$display("%0t: average mismatch, expected %0d, actual %0d", $time,
						want, average_bus.average);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_bus.valid && sample_bus.ready) ||
				(average_bus.valid && average_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		sample_bus.valid = 1'b0;
		sample_bus.sample = '0;
		idle_enable = 1'b1;
		hold_req = 1'b0;
		failures = 0;
		words_sent = 0;
		windows_sent = 0;
		averages_checked = 0;
		quiet_cycles = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_random_windows(36);
		test_streaming(6);
		test_backpressure();
		sample_bus.valid <= 1'b0;

		while (expected_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d sample words in %0d windows of varied shape, with idle gaps,",
			words_sent, windows_sent);
		$display("a gap-free stretch and a long receiver hold-off; %0d averages checked.",
			averages_checked);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
src/tmsf_pkg.sv
src/tmsf_if.sv
src/tmsf_cell.sv
src/tmsf_accum.sv
src/trimmed_mean_sample_filter.sv
sim/tb_trimmed_mean_sample_filter.sv
